>>> hdl/gsm7_septet_packer_segmenter_unit_defines.svh
// assertion helpers used by the checker file
`ifndef GSM7_SEPTET_PACKER_SEGMENTER_UNIT_DEFINES_SVH
`define GSM7_SEPTET_PACKER_SEGMENTER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define GSM7SP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define GSM7SP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gsm7sp_pkg.sv
package gsm7sp_pkg;

  localparam int unsigned SPP_W      = 8;
  localparam int unsigned PAD_W      = 3;
  localparam int unsigned CODE_W     = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HELD_W     = 3;
  localparam int unsigned MAX_RES    = 4;
  localparam int unsigned RES_IDX_W  = 2;
  localparam int unsigned RES_CNT_W  = 3;
  localparam int unsigned JOB_DEPTH  = 2;
  localparam int unsigned JOB_AW     = 1;
  localparam int unsigned JOB_CNT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CODE_W-1:0] ESC_SEPTET = 7'h1B;
  localparam logic [SPP_W-1:0]  MIN_BUDGET = 8'd2;
  localparam logic [SPP_W-1:0]  RESET_SPP  = 8'd160;

  localparam logic [CFG_IDX_W-1:0] REG_SEPTETS_PER_PDU = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BITS        = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              pdu_end;
  } res_t;

  // all results caused by one request
  typedef struct packed {
    res_t [MAX_RES-1:0]   res;
    logic [RES_CNT_W-1:0] cnt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> hdl/gsm7sp_front.sv
module gsm7sp_front import gsm7sp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CODE_W-1:0]     in_char_code,
  input  logic                  in_extended,
  input  logic                  in_message_end,
  input  fifo_stat_t            fifo_stat,
  output logic                  job_push,
  output job_t                  job
);

  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] bbuf;
    logic [HELD_W-1:0] held;
  } push_t;

  function automatic push_t push_septet(logic [BYTE_W-1:0] bbuf, logic [HELD_W-1:0] held,
                                        logic [CODE_W-1:0] s);
    logic [BYTE_W+CODE_W-1:0] wide;
    logic [HELD_W:0]          sum;
    push_t                    p;
    wide   = {{CODE_W{1'b0}}, bbuf} | ({{BYTE_W{1'b0}}, s} << held);
    sum    = {1'b0, held} + (HELD_W+1)'(CODE_W);
    p.emit = sum[HELD_W];
    p.data = wide[BYTE_W-1:0];
    p.held = sum[HELD_W-1:0];
    if (sum[HELD_W]) begin
      p.bbuf = {1'b0, wide[BYTE_W+CODE_W-1:BYTE_W]};
    end else begin
      p.bbuf = wide[BYTE_W-1:0];
    end
    return p;
  endfunction

  logic [SPP_W-1:0]  spp_r, spp_nxt;
  logic [PAD_W-1:0]  pad_r, pad_nxt;
  logic [BYTE_W-1:0] buf_r, buf_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [SPP_W-1:0]  left_r, left_nxt;
  logic              open_r, open_nxt;

  logic              accept;
  logic [SPP_W-1:0]  cost;
  logic [SPP_W-1:0]  budget;
  logic              close_first;
  logic              fresh;
  logic [BYTE_W-1:0] b;
  logic [HELD_W-1:0] h;
  logic [SPP_W-1:0]  l;
  logic [RES_CNT_W-1:0] k;
  push_t             p_esc, p_chr;

  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;
  assign cost     = in_extended ? 8'd2 : 8'd1;
  assign budget   = (spp_r < MIN_BUDGET) ? MIN_BUDGET : spp_r;

  always_comb begin
    spp_nxt = spp_r;
    pad_nxt = pad_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SEPTETS_PER_PDU: spp_nxt = cfg_wdata;
        REG_PAD_BITS:        pad_nxt = cfg_wdata[PAD_W-1:0];
        default:             spp_nxt = spp_r;
      endcase
    end
  end

  always_comb begin
    job         = '0;
    k           = '0;
    close_first = open_r && (left_r < cost);
    fresh       = close_first || !open_r;

    // character does not fit: close the open pdu first
    if (close_first) begin
      job.res[k[RES_IDX_W-1:0]].data       = (held_r != '0) ? buf_r : '0;
      job.res[k[RES_IDX_W-1:0]].byte_valid = (held_r != '0);
      job.res[k[RES_IDX_W-1:0]].pdu_end    = 1'b1;
      k = k + 1'b1;
    end

    b = fresh ? '0 : buf_r;
    h = fresh ? pad_r : held_r;
    l = fresh ? budget : left_r;

    p_esc = push_septet(b, h, ESC_SEPTET);
    if (in_extended) begin
      if (p_esc.emit) begin
        job.res[k[RES_IDX_W-1:0]].data       = p_esc.data;
        job.res[k[RES_IDX_W-1:0]].byte_valid = 1'b1;
        job.res[k[RES_IDX_W-1:0]].pdu_end    = 1'b0;
        k = k + 1'b1;
      end
      b = p_esc.bbuf;
      h = p_esc.held;
    end

    p_chr = push_septet(b, h, in_char_code);
    if (p_chr.emit) begin
      job.res[k[RES_IDX_W-1:0]].data       = p_chr.data;
      job.res[k[RES_IDX_W-1:0]].byte_valid = 1'b1;
      job.res[k[RES_IDX_W-1:0]].pdu_end    = 1'b0;
      k = k + 1'b1;
    end
    b = p_chr.bbuf;
    h = p_chr.held;
    l = l - cost;

    if (in_message_end) begin
      job.res[k[RES_IDX_W-1:0]].data       = (h != '0) ? b : '0;
      job.res[k[RES_IDX_W-1:0]].byte_valid = (h != '0);
      job.res[k[RES_IDX_W-1:0]].pdu_end    = 1'b1;
      k = k + 1'b1;
      buf_nxt  = '0;
      held_nxt = '0;
      left_nxt = '0;
      open_nxt = 1'b0;
    end else begin
      buf_nxt  = b;
      held_nxt = h;
      left_nxt = l;
      open_nxt = 1'b1;
    end
    job.cnt = k;
  end

  assign job_push = accept && (job.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r  <= RESET_SPP;
      pad_r  <= '0;
      buf_r  <= '0;
      held_r <= '0;
      left_r <= '0;
      open_r <= 1'b0;
    end else begin
      spp_r <= spp_nxt;
      pad_r <= pad_nxt;
      if (accept) begin
        buf_r  <= buf_nxt;
        held_r <= held_nxt;
        left_r <= left_nxt;
        open_r <= open_nxt;
      end
    end
  end

endmodule

>>> hdl/gsm7sp_job_fifo.sv
module gsm7sp_job_fifo import gsm7sp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       pop_job,
  output fifo_stat_t stat
);

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [JOB_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [JOB_CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == JOB_CNT_W'(JOB_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_job    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + JOB_CNT_W'(push) - JOB_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hdl/gsm7sp_drain.sv
module gsm7sp_drain import gsm7sp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_stat_t        fifo_stat,
  input  job_t              head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_byte_valid,
  output logic              out_pdu_end,
  output logic              out_run_last
);

  job_t                 job_r, job_nxt;
  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                 busy_r, busy_nxt;
  logic                 is_last;
  res_t                 cur;

  assign is_last = (({1'b0, idx_r} + 1'b1) == job_r.cnt);
  assign cur     = job_r.res[idx_r];
  // take the next job as the current one finishes, so runs go out without gaps
  assign pop     = !fifo_stat.empty && (!busy_r || (out_ready && is_last));

  always_comb begin
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      job_nxt  = head_job;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r && out_ready) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  assign out_valid      = busy_r;
  assign out_byte       = cur.data;
  assign out_byte_valid = cur.byte_valid;
  assign out_pdu_end    = cur.pdu_end;
  assign out_run_last   = is_last;

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

>>> hdl/gsm7_septet_packer_segmenter_unit.sv
// gsm 7-bit septet packer with pdu segmentation
// input channel (in_valid/in_ready): one character code per request, with an
//   extended flag (escape septet sent first) and a message-end flag
// result channel (out_valid/out_ready): zero to four results per request, each
//   a packed octet or a bare end marker, with pdu_end and run_last flags
// config port: cfg_we with cfg_index 0 = septets per pdu, 1 = pad bits;
//   the user must write it only while the block is idle; the block leaves this unchecked; no read-back
// the front packs one request per cycle into a job while the queue has room;
//   a two-entry job queue feeds the back end, which sends one result per cycle
//   while out_ready is high; with the back end idle, a request's first result
//   goes through the job queue and the back end's job register before it is offered
// sustained rate: one request per cycle while each yields at most one result
//   and out_ready stays high; requests with more results are limited by the
//   one-result-per-cycle output port
// a request that yields no result leaves nothing in the queue
// reset: no pdu open, budget 160, no pad bits, queue empty
// receiver stall: results hold on the port; once the queue is full in_ready
//   drops until the back end frees an entry
module gsm7_septet_packer_segmenter_unit import gsm7sp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CODE_W-1:0]     in_char_code,
  input  logic                  in_extended,
  input  logic                  in_message_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_byte_valid,
  output logic                  out_pdu_end,
  output logic                  out_run_last
);

  fifo_stat_t fifo_stat;
  logic       job_push;
  job_t       push_job;
  logic       job_pop;
  job_t       head_job;

  gsm7sp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_extended    (in_extended),
    .in_message_end (in_message_end),
    .fifo_stat      (fifo_stat),
    .job_push       (job_push),
    .job            (push_job)
  );

  gsm7sp_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .pop_job  (head_job),
    .stat     (fifo_stat)
  );

  gsm7sp_drain u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_stat      (fifo_stat),
    .head_job       (head_job),
    .pop            (job_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_pdu_end    (out_pdu_end),
    .out_run_last   (out_run_last)
  );

endmodule

>>> hdl/gsm7sp_checker.sv
`include "gsm7_septet_packer_segmenter_unit_defines.svh"

module gsm7sp_checker import gsm7sp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [CODE_W-1:0]     in_char_code,
  input logic                  in_extended,
  input logic                  in_message_end,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [BYTE_W-1:0]     out_byte,
  input logic                  out_byte_valid,
  input logic                  out_pdu_end,
  input logic                  out_run_last
);

  // stalled result holds
  `GSM7SP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_byte_valid) && $stable(out_pdu_end) && $stable(out_run_last), "stalled result changed")

  // a bare marker only closes a pdu and carries a zero byte
  `GSM7SP_ASSERT_NOW(a_bare_marker, out_valid && !out_byte_valid, out_pdu_end && (out_byte == 8'd0), "bare marker without pdu_end or with data")

  // the rest of a request's run follows without a gap
  `GSM7SP_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !out_run_last, out_valid, "gap inside a result run")

endmodule

bind gsm7_septet_packer_segmenter_unit gsm7sp_checker u_gsm7sp_checker (.*);
